// ===== design/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// shared codes and field widths of the time-ordered event queue
// ----------------------------------------------------------------------------
package teq_pkg;

    // field widths of one input and one result word
    localparam int TIME_W   = 32;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // stream bus widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = STATUS_W;

    // request selector carried on the slave tuser
    typedef enum logic [S_TUSER_W-1:0] {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    // result status carried on the master tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED     = 2'd0,
        ST_POPPED     = 2'd1,
        ST_POP_EMPTY  = 2'd2,
        ST_PUSH_FULL  = 2'd3
    } t_status;

endpackage

// ===== design/teq_ram.sv =====
// ----------------------------------------------------------------------------
// teq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module teq_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/time_ordered_event_queue.sv =====
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// bounded event queue kept in ascending time order, equal times first in
// first out
// ----------------------------------------------------------------------------
// Events sit in one ram used as a ring: a pop reads the slot at the head and
// advances the head, a push walks from the tail toward the head, moving every
// later event up one slot until it meets one whose time is equal or earlier,
// and drops the new event into the hole. One comparator and one ring-address
// adder do all the work, one ram read and one ram write per step. A pop passes
// through a read state, a capture state and the done state. A push alternates
// a read state and a compare state until the new event is placed, then ends in
// the done state. A push into a full queue or a pop of an empty one goes
// straight to the done state. The last step also waits while an earlier result
// word is still held on the master side. The slave side is ready only between
// requests; a finished word waits in the output register and does not hold off
// the next request. Every request gives exactly one result word.
// ----------------------------------------------------------------------------
module time_ordered_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // event_time[31:0], event_kind[32], process_id[48:33], zero fill
    input  logic [teq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [teq_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // result side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_time[31:0], out_kind[32], out_process[48:33], fill_level[53:49]
    output logic [teq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [teq_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    import teq_pkg::*;

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = TIME_W + 1 + ID_BITS;
    localparam int KPOS = TIME_W;
    localparam int PPOS = TIME_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_CMP,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_j, n_j;
    logic [EW-1:0]       r_new, n_new;
    t_status             r_st, n_st;
    logic [TIME_W-1:0]   r_rtime, n_rtime;
    logic                r_rkind, n_rkind;
    logic [PID_W-1:0]    r_rpid, n_rpid;
    logic                r_ov, n_ov;
    logic [M_TDATA_W-1:0] r_odata, n_odata;
    t_status             r_ouser, n_ouser;

    logic                w_acc;
    logic [ID_BITS-1:0]  w_in_pid;
    logic [PID_W-1:0]    w_rd_pid;
    logic [FILL_W-1:0]   w_fill;
    logic [AW-1:0]       w_off;
    logic [AW:0]         w_sum;
    logic [AW-1:0]       w_addr;
    logic                w_we;
    logic [EW-1:0]       w_wdata;
    logic [EW-1:0]       w_rdata;
    logic                w_later;
    logic                w_full;
    logic                w_empty;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    // process id resized between the port and the stored width
    for (genvar g = 0; g < ID_BITS; g++) begin : g_in_pid
        if (g < PID_W) begin : g_bit
            assign w_in_pid[g] = s_axis_tdata[TIME_W + 1 + g];
        end else begin : g_zero
            assign w_in_pid[g] = 1'b0;
        end
    end
    for (genvar g = 0; g < PID_W; g++) begin : g_rd_pid
        if (g < ID_BITS) begin : g_bit
            assign w_rd_pid[g] = w_rdata[PPOS + g];
        end else begin : g_zero
            assign w_rd_pid[g] = 1'b0;
        end
    end
    for (genvar g = 0; g < FILL_W; g++) begin : g_fill
        if (g < CW) begin : g_bit
            assign w_fill[g] = r_count[g];
        end else begin : g_zero
            assign w_fill[g] = 1'b0;
        end
    end

    // shared ring address unit: head plus logical offset, wrapped once
    always_comb begin
        unique case (r_state)
            S_PUSH_RD:  w_off = (r_j == '0) ? '0 : AW'(r_j - 1'b1);
            S_PUSH_CMP: w_off = r_j[AW-1:0];
            default:    w_off = '0;
        endcase
        w_sum = {1'b0, r_head} + {1'b0, w_off};
        if (w_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
            w_addr = AW'(w_sum - (AW + 1)'(QUEUE_DEPTH));
        end else begin
            w_addr = w_sum[AW-1:0];
        end
    end

    // shared comparator: stored event strictly later than the new one
    assign w_later = (w_rdata[TIME_W-1:0] > r_new[TIME_W-1:0]);

    // ram write: move an event up one slot or drop the new one in
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_new;
        if (r_state == S_PUSH_RD && r_j == '0) begin
            w_we = 1'b1;
        end else if (r_state == S_PUSH_CMP) begin
            w_we = 1'b1;
            if (w_later) begin
                w_wdata = w_rdata;
            end
        end
    end

    teq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_j     = r_j;
        n_new   = r_new;
        n_st    = r_st;
        n_rtime = r_rtime;
        n_rkind = r_rkind;
        n_rpid  = r_rpid;
        n_ov    = r_ov;
        n_odata = r_odata;
        n_ouser = r_ouser;

        // output word taken
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_new   = {w_in_pid, s_axis_tdata[TIME_W], s_axis_tdata[TIME_W-1:0]};
                    n_rtime = '0;
                    n_rkind = 1'b0;
                    n_rpid  = '0;
                    n_j     = r_count;
                    if (t_mode'(s_axis_tuser) == MODE_PUSH) begin
                        if (w_full) begin
                            n_st    = ST_PUSH_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_st    = ST_PUSHED;
                            n_state = S_PUSH_RD;
                        end
                    end else begin
                        if (w_empty) begin
                            n_st    = ST_POP_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_st    = ST_POPPED;
                            n_state = S_POP_RD;
                        end
                    end
                end
            end
            S_PUSH_RD: begin
                if (r_j == '0) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                if (w_later) begin
                    n_j     = r_j - 1'b1;
                    n_state = S_PUSH_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_CMP;
            end
            S_POP_CMP: begin
                n_rtime = w_rdata[TIME_W-1:0];
                n_rkind = w_rdata[KPOS];
                n_rpid  = w_rd_pid;
                n_count = r_count - 1'b1;
                n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = {2'b00, w_fill, r_rpid, r_rkind, r_rtime};
                    n_ouser = r_st;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_ov    <= n_ov;
        end
        r_j     <= n_j;
        r_new   <= n_new;
        r_st    <= n_st;
        r_rtime <= n_rtime;
        r_rkind <= n_rkind;
        r_rpid  <= n_rpid;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTH
    // stored count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("event count above queue depth");

    // an accepted request keeps the slave side not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !s_axis_tready)
        else $error("ready right after accept");

    // a successful push always leaves at least one stored event
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_PUSHED) |-> (m_axis_tdata[53:49] != '0))
        else $error("push reported with empty queue");
`endif

endmodule
